>>> rtl/spq_pkg.sv
// Package for the stable priority queue unit.
// Holds request and response payload types, request codes, controller states and commands.
// Used by every module of the block.
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [7:0]         item_data;
        logic signed [15:0] item_prio;
    } t_req;

    typedef struct packed {
        logic               front_valid;
        logic [7:0]         front_data;
        logic signed [15:0] front_prio;
        logic [4:0]         entry_count;
        logic               queue_full;
        logic               op_refused;
    } t_rsp;

    typedef enum logic {
        ST_IDLE,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic apply;
        logic load_rsp;
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/spq_datapath.sv
// Datapath of the stable priority queue: a sorted row of entry cells and the response register.
// Depends on spq_pkg; driven by commands from spq_controller.
`default_nettype none

module spq_datapath #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire spq_pkg::t_cmd i_cmd,
    input  wire spq_pkg::t_req i_req,
    output spq_pkg::t_rsp      o_rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]         r_data [QUEUE_DEPTH];
    logic signed [15:0] r_prio [QUEUE_DEPTH];
    logic [7:0]         n_data [QUEUE_DEPTH];
    logic signed [15:0] n_prio [QUEUE_DEPTH];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_refused;
    logic               n_refused;
    spq_pkg::t_rsp      r_rsp;
    spq_pkg::t_rsp      n_rsp;

    logic [QUEUE_DEPTH-1:0] w_le;
    logic                   w_full;
    logic                   w_empty;
    logic [CW+4:0]          w_cnt_ext;

    assign w_full    = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_cnt_ext = {5'b0, r_count};

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_le[i] = (CW'(i) < r_count) && (r_prio[i] <= i_req.item_prio);
        end
    end

    always_comb begin
        n_data    = r_data;
        n_prio    = r_prio;
        n_count   = r_count;
        n_refused = r_refused;
        if (i_cmd.apply) begin
            n_refused = 1'b0;
            if (i_req.req_type == spq_pkg::REQ_INSERT) begin
                if (w_full) begin
                    n_refused = 1'b1;
                end else begin
                    n_count = r_count + CW'(1);
                    if (!w_le[0]) begin
                        n_data[0] = i_req.item_data;
                        n_prio[0] = i_req.item_prio;
                    end
                    for (int i = 1; i < QUEUE_DEPTH; i++) begin
                        if (!w_le[i]) begin
                            if (w_le[i-1]) begin
                                n_data[i] = i_req.item_data;
                                n_prio[i] = i_req.item_prio;
                            end else begin
                                n_data[i] = r_data[i-1];
                                n_prio[i] = r_prio[i-1];
                            end
                        end
                    end
                end
            end else begin
                if (w_empty) begin
                    n_refused = 1'b1;
                end else begin
                    n_count = r_count - CW'(1);
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        n_data[i] = r_data[i+1];
                        n_prio[i] = r_prio[i+1];
                    end
                end
            end
        end
    end

    always_comb begin
        n_rsp = r_rsp;
        if (i_cmd.load_rsp) begin
            n_rsp.front_valid = !w_empty;
            n_rsp.front_data  = w_empty ? 8'd0 : r_data[0];
            n_rsp.front_prio  = w_empty ? 16'sd0 : r_prio[0];
            n_rsp.entry_count = w_cnt_ext[4:0];
            n_rsp.queue_full  = w_full;
            n_rsp.op_refused  = r_refused;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data    <= n_data;
        r_prio    <= n_prio;
        r_refused <= n_refused;
        r_rsp     <= n_rsp;
    end

    assign o_rsp = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply && i_req.req_type == spq_pkg::REQ_INSERT && !w_full
        |=> r_count == $past(r_count) + CW'(1) && !r_refused)
        else $error("Accepted insert did not add one entry.");

endmodule

`default_nettype wire

>>> rtl/spq_controller.sv
// Controller of the stable priority queue: request acceptance and response handoff.
// Depends on spq_pkg; issues commands to spq_datapath.
`default_nettype none

module spq_controller (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_stall,
    output logic          o_rsp_valid,
    input  wire logic     i_rsp_stall,
    output spq_pkg::t_cmd o_cmd
);

    spq_pkg::t_state r_state;
    spq_pkg::t_state n_state;
    logic            r_rsp_valid;
    logic            n_rsp_valid;
    logic            w_accept;

    assign o_req_stall = (r_state != spq_pkg::ST_IDLE);
    assign w_accept    = i_req_valid && !o_req_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spq_pkg::ST_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.apply    = 1'b0;
        o_cmd.load_rsp = 1'b0;
        n_rsp_valid    = r_rsp_valid && i_rsp_stall;
        unique case (r_state)
            spq_pkg::ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.apply = 1'b1;
                    n_state     = spq_pkg::ST_REPORT;
                end
            end
            spq_pkg::ST_REPORT: begin
                if (!r_rsp_valid || !i_rsp_stall) begin
                    o_cmd.load_rsp = 1'b1;
                    n_rsp_valid    = 1'b1;
                    n_state        = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;

    a_accept_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == spq_pkg::ST_REPORT && o_req_stall)
        else $error("Accepted request did not move to the report state.");

    a_rsp_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && i_rsp_stall |=> r_rsp_valid)
        else $error("Stalled response was dropped.");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_rsp |-> !r_rsp_valid || !i_rsp_stall)
        else $error("Response register overwritten while stalled.");

endmodule

`default_nettype wire

>>> rtl/stable_priority_queue_unit.sv
// Top level of the stable priority queue unit.
// Instantiates spq_controller and spq_datapath; types come from spq_pkg.
//
//   Channel   Direction  Handshake                    Payload
//   request   in         i_req_valid / o_req_stall    i_req (spq_pkg::t_req)
//   response  out        o_rsp_valid / i_rsp_stall    o_rsp (spq_pkg::t_rsp)
//
// Each request passes the idle and report states: the entry cells shift as it is accepted
// in the idle state, and the response register loads from the front cell in the report
// state. No new request is taken until that response has been loaded.
// A stalled response holds the unit in its report step until the response register frees.
// Reset empties the queue at once; no clearing pass is needed.
`default_nettype none

module stable_priority_queue_unit #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_stall,
    input  wire spq_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_stall,
    output spq_pkg::t_rsp      o_rsp
);

    spq_pkg::t_cmd w_cmd;

    spq_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_cmd       (w_cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
